// ===== sv/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: positional list shared types and constants
// Sizes, operation codes and status codes used by the list and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int CAPACITY = 128;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ECNT_W   = 8;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // common width for position / count compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== sv/pli_req_if.sv =====
// ----------------------------------------------------------------------------
// pli_req_if: list operation request channel
// Valid/ready channel carrying one list operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_req_if
  import pli_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);

endinterface

`default_nettype wire

// ===== sv/pli_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pli_rsp_if: list operation response channel
// Valid/ready channel carrying the result of one list operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_rsp_if
  import pli_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic signed [VAL_W-1:0] read_value;
  logic [ECNT_W-1:0]   entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);

endinterface

`default_nettype wire

// ===== sv/positional_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top: ordered list with insert/remove at index
// Keeps up to CAPACITY signed words and a count; entries move one per cycle
// through a single-port-write / registered-read memory under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | signals
//  req_i   | in  | valid, ready, kind, position, value
//  rsp_o   | out | valid, ready, status, read_value, entry_count
//
//  An insert at p < count moves the entries from p upward, one entry per cycle, and
//  then writes the value; a remove below the last entry moves the entries above p
//  down. Requests are taken only while idle. Reset clears count and control; memory
//  stays undefined. A response waits in the output register until rsp_o.ready; the
//  next request may be taken meanwhile, but its response stalls until the register
//  is free.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_top
  import pli_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pli_req_if.sink      req_i,
  pli_rsp_if.source    rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_WRVAL,
    S_RDWAIT,
    S_RESP
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        cur_q;
  logic [IDX_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    up_q;
  logic                    rd_sel_q;
  logic [STATUS_W-1:0]     status_q;
  logic                    pend_q;
  logic [IDX_W-1:0]        pend_addr_q;

  logic                    rsp_valid_q;
  logic [STATUS_W-1:0]     rsp_status_q;
  logic signed [VAL_W-1:0] rsp_value_q;
  logic [ECNT_W-1:0]       rsp_count_q;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata_q;

  // decoded request
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    cnt_c;
  logic [CMP_W-1:0]    cnt_m1;
  logic [CMP_W-1:0]    pos_p1;
  logic [CMP_W-1:0]    cnt_ext;
  logic [STATUS_W-1:0] dec_status;
  logic [CNT_W-1:0]    dec_count;
  state_e              dec_next;
  logic [IDX_W-1:0]    dec_cur;
  logic                dec_up;
  logic                dec_rd;

  logic                    req_fire;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    shift_last;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    pos_c      = CMP_W'(req_i.position);
    cnt_c      = CMP_W'(count_q);
    cnt_m1     = cnt_c - 1'b1;
    pos_p1     = pos_c + 1'b1;
    dec_status = ST_OK;
    dec_count  = count_q;
    dec_next   = S_RESP;
    dec_cur    = pos_c[IDX_W-1:0];
    dec_up     = 1'b0;
    dec_rd     = 1'b0;
    unique case (req_i.kind)
      KIND_CLEAR: begin
        dec_count = '0;
      end
      KIND_INSERT: begin
        priority if (cnt_c >= CMP_W'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          dec_status = ST_RANGE;
        end else begin
          dec_count = count_q + 1'b1;
          dec_up    = 1'b1;
          if (pos_c < cnt_c) begin
            dec_cur  = cnt_m1[IDX_W-1:0];
            dec_next = S_SHIFT;
          end else begin
            dec_next = S_WRVAL;
          end
        end
      end
      KIND_UPDATE, KIND_REMOVE, KIND_READ: begin
        priority if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          dec_status = ST_RANGE;
        end else if (req_i.kind == KIND_UPDATE) begin
          dec_next = S_WRVAL;
        end else if (req_i.kind == KIND_REMOVE) begin
          dec_count = count_q - 1'b1;
          if (pos_p1 < cnt_c) begin
            dec_cur  = pos_p1[IDX_W-1:0];
            dec_next = S_SHIFT;
          end
        end else begin
          dec_rd   = 1'b1;
          dec_next = S_RDWAIT;
        end
      end
      default: ;
    endcase
  end

  // insert walks down to the target, remove walks up to the new count
  assign shift_last = up_q ? (cur_q == pos_q) : (CNT_W'(cur_q) == count_q);
  assign cnt_ext    = CMP_W'(count_q);

  // a pending shift write and the value write never fall in the same cycle
  assign we    = pend_q || (state_q == S_WRVAL);
  assign waddr = pend_q ? pend_addr_q : pos_q;
  assign wdata = pend_q ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cur_q        <= '0;
      pos_q        <= '0;
      val_q        <= '0;
      up_q         <= 1'b0;
      rd_sel_q     <= 1'b0;
      status_q     <= ST_OK;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_OK;
      rsp_value_q  <= '0;
      rsp_count_q  <= '0;
    end else begin
      pend_q <= (state_q == S_SHIFT);
      if (rsp_valid_q && rsp_o.ready && (state_q != S_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            state_q  <= dec_next;
            count_q  <= dec_count;
            cur_q    <= dec_cur;
            pos_q    <= pos_c[IDX_W-1:0];
            val_q    <= req_i.value;
            up_q     <= dec_up;
            rd_sel_q <= dec_rd;
            status_q <= dec_status;
          end
        end
        S_SHIFT: begin
          pend_addr_q <= up_q ? cur_q + 1'b1 : cur_q - 1'b1;
          if (shift_last) begin
            state_q <= S_DRAIN;
          end else begin
            cur_q <= up_q ? cur_q - 1'b1 : cur_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= up_q ? S_WRVAL : S_RESP;
        end
        S_WRVAL: begin
          state_q <= S_RESP;
        end
        S_RDWAIT: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            rsp_value_q  <= rd_sel_q ? rdata_q : '0;
            rsp_count_q  <= cnt_ext[ECNT_W-1:0];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.entry_count = rsp_count_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  localparam logic [CMP_W-1:0] CapCmp = CMP_W'(CAPACITY);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CapCmp)
    else $error("list count above capacity");

  a_write_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CNT_W'(waddr) < count_q))
    else $error("memory write outside the live list");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> (rsp_o.entry_count == CapCmp[ECNT_W-1:0]))
    else $error("full status with list not at capacity");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.read_value == '0))
    else $error("failed request returned data");

endmodule

`default_nettype wire

// ===== bench/pli_result_checker.sv =====
// ----------------------------------------------------------------------------
// pli_result_checker: response checker for the positional list
// Watches both channels, keeps a shadow copy of the list, predicts one
// response per accepted request and compares it field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_result_checker
  import pli_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pli_req_if                 req_i,
  pli_rsp_if                 rsp_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output logic [ECNT_W-1:0]  list_len_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [ECNT_W-1:0]       entry_count;
  } list_result_t;

  logic signed [VAL_W-1:0] list_mem [CAPACITY];
  int                      list_len;
  list_result_t            awaited_rsp_q [$];
  int unsigned             mismatches;

  initial begin
    list_len     = 0;
    mismatches   = 0;
    fail_count_o = 0;
    pending_o    = 0;
    list_len_o   = '0;
  end

  // applies one request to the shadow list and returns the response it owes
  function automatic list_result_t list_apply(input logic [KIND_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int           idx;
    int           at;
    at             = int'(pos);
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      KIND_CLEAR: list_len = 0;
      KIND_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (at > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (idx = list_len; idx > at; idx--) list_mem[idx] = list_mem[idx-1];
          list_mem[at] = val;
          list_len++;
        end
      end
      KIND_UPDATE, KIND_REMOVE, KIND_READ: begin
        // emptiness wins over a bad position
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (at >= list_len) begin
          res.status = ST_RANGE;
        end else if (op == KIND_UPDATE) begin
          list_mem[at] = val;
        end else if (op == KIND_REMOVE) begin
          for (idx = at; idx + 1 < list_len; idx++) list_mem[idx] = list_mem[idx+1];
          list_len--;
        end else begin
          res.read_value = list_mem[at];
        end
      end
      default: ;
    endcase
    res.entry_count = ECNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk_i) begin
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      awaited_rsp_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected response: status %0d value %0d count %0d",
                     rsp_i.status, rsp_i.read_value, rsp_i.entry_count);
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_i.status !== want.status || rsp_i.read_value !== want.read_value ||
              rsp_i.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("response mismatch: expected status %0d value %0d count %0d, %s %0d %0d %0d",
                       want.status, want.read_value, want.entry_count,
                       "got status/value/count", rsp_i.status, rsp_i.read_value,
                       rsp_i.entry_count);
          end
        end
      end
      // a response never comes back in the cycle its request is taken
      if (req_i.valid && req_i.ready)
        awaited_rsp_q.push_back(list_apply(req_i.kind, req_i.position, req_i.value));
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_rsp_q.size();
    list_len_o   <= ECNT_W'(list_len);
  end

endmodule

`default_nettype wire

// ===== bench/positional_list_insert_delete_top_test.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top_test: positional list testbench
// Directed edge cases, then random list edits and bulk loads under three
// idle/stall profiles; a side checker predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_top_test;
  import pli_pkg::*;

  localparam int unsigned PHASE_ITEMS = 650;
  localparam int unsigned IDLE_LIMIT  = 4000;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  int unsigned       src_gap_pct;
  int unsigned       sink_stall_pct;
  int unsigned       requests_sent;
  int unsigned       idle_cycles;
  int unsigned       fail_cnt;
  int unsigned       pending_cnt;
  logic [ECNT_W-1:0] list_len_w;

  pli_req_if req_ch ();
  pli_rsp_if rsp_ch ();

  positional_list_insert_delete_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  pli_result_checker list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt),
    .list_len_o   (list_len_w)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < src_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    requests_sent++;
  endtask

  // hold off new requests until every response is back
  task automatic wait_for_results;
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // clear, then append n entries; a full load also probes insert-on-full
  task automatic bulk_load(input int n);
    int i;
    send_request(KIND_CLEAR, POS_W'($urandom), pick_word());
    for (i = 0; i < n; i++) send_request(KIND_INSERT, POS_W'(i), pick_word());
    if (n == CAPACITY) send_request(KIND_INSERT, POS_W'($urandom_range(CAPACITY)), pick_word());
  endtask

  task automatic run_directed;
    int k;
    send_request(KIND_READ, 0, 0);
    send_request(KIND_UPDATE, 0, 5);
    send_request(KIND_REMOVE, 0, 0);
    send_request(KIND_READ, POS_W'(CAPACITY), 0);
    send_request(KIND_INSERT, 1, 7);
    send_request(KIND_INSERT, 0, {1'b0, {(VAL_W-1){1'b1}}});
    send_request(KIND_INSERT, 1, {1'b1, {(VAL_W-1){1'b0}}});
    send_request(KIND_INSERT, 0, '1);
    send_request(KIND_INSERT, 4, 9);
    send_request(KIND_INSERT, 3, 0);
    for (k = 0; k < 5; k++) send_request(KIND_READ, POS_W'(k), 0);
    send_request(KIND_UPDATE, 2, $urandom);
    send_request(KIND_UPDATE, POS_W'(CAPACITY), 1);
    send_request(KIND_REMOVE, 0, 0);
    send_request(KIND_REMOVE, 4, 0);
    for (k = int'(KIND_READ) + 1; k < (1 << KIND_W); k++)
      send_request(KIND_W'(k), POS_W'($urandom), $urandom);
    send_request(KIND_REMOVE, 2, 0);
    send_request(KIND_CLEAR, 0, 0);
    send_request(KIND_READ, 0, 0);
  endtask

  // full list: both longest shifts and a bad position while full
  task automatic fill_and_probe;
    bulk_load(CAPACITY);
    send_request(KIND_READ, POS_W'(CAPACITY - 1), 0);
    send_request(KIND_UPDATE, POS_W'(CAPACITY - 1), {1'b1, {(VAL_W-1){1'b0}}});
    send_request(KIND_REMOVE, 0, 0);
    send_request(KIND_INSERT, 0, pick_word());
    send_request(KIND_INSERT, POS_W'(CAPACITY), pick_word());
    send_request(KIND_READ, 0, 0);
    send_request(KIND_READ, POS_W'(CAPACITY - 1), 0);
  endtask

  task automatic send_random_op;
    int               len;
    int               pick;
    logic [POS_W-1:0] pos;
    // checker length may lag by one request; good enough to aim positions
    len  = int'(list_len_w);
    pick = $urandom_range(99);
    if (pick < 35) begin
      pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(CAPACITY)) :
                                       POS_W'($urandom_range(len));
      send_request(KIND_INSERT, pos, pick_word());
    end else if (pick < 92) begin
      pos = (len == 0 || $urandom_range(9) == 0) ? POS_W'($urandom_range(CAPACITY)) :
                                                   POS_W'($urandom_range(len - 1));
      if (pick < 55)      send_request(KIND_REMOVE, pos, pick_word());
      else if (pick < 67) send_request(KIND_UPDATE, pos, pick_word());
      else                send_request(KIND_READ, pos, pick_word());
    end else if (pick < 95) begin
      send_request(KIND_CLEAR, POS_W'($urandom), pick_word());
    end else if (pick < 98) begin
      send_request(KIND_W'($urandom_range(int'(KIND_READ) + 1, (1 << KIND_W) - 1)),
                   POS_W'($urandom), $urandom);
    end else begin
      wait_for_results();
    end
  endtask

  initial begin
    int unsigned phase_end;
    int          ph;
    int          n;
    req_ch.valid    = 1'b0;
    req_ch.kind     = KIND_CLEAR;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    src_gap_pct     = 29;
    sink_stall_pct  = 83;
    requests_sent   = 0;
    idle_cycles     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    phase_end = requests_sent;
    fill_and_probe();

    for (ph = 0; ph < 3; ph++) begin
      phase_end += PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        if ($urandom_range(3) == 0) begin
          n = ($urandom_range(4) == 0) ? CAPACITY : $urandom_range(1, 48);
          bulk_load(n);
        end
        repeat ($urandom_range(10, 40)) send_random_op();
      end
      wait_for_results();
      if (ph == 0) begin
        src_gap_pct    <= 83;
        sink_stall_pct <= 29;
      end else begin
        src_gap_pct    <= 0;
        sink_stall_pct <= 0;
      end
    end

    wait_for_results();
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
